// ===== design/swft_pkg.sv =====
package swft_pkg;

	localparam int SEQ_W     = 32;
	localparam int CNT_W     = 16;
	localparam int TOT_W     = 64;
	localparam int EST_W     = 33;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_WRAP_TOP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_BOTTOM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEQ_MAX     = 2'd2;

	localparam logic [SEQ_W-1:0] WRAP_TOP_RESET    = 32'hF000_0000;
	localparam logic [SEQ_W-1:0] WRAP_BOTTOM_RESET = 32'h1000_0000;
	localparam logic [SEQ_W-1:0] SEQ_MAX_RESET     = 32'hFFFF_FFFF;

	localparam logic MODE_PACKET = 1'b0;
	localparam logic MODE_CLEAR  = 1'b1;

	// One classified word as it waits in the queue between front and back.
	typedef struct packed {
		logic             clear;
		logic [SEQ_W-1:0] seq;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

endpackage

// ===== design/swft_if.sv =====
interface swft_pkt_if;
	import swft_pkg::*;
	logic             valid;
	logic             ready;
	logic             mode;
	logic [SEQ_W-1:0] seq_no;
	logic [CNT_W-1:0] record_count;

	modport source (output valid, output mode, output seq_no, output record_count, input ready);
	modport sink (input valid, input mode, input seq_no, input record_count, output ready);
endinterface

interface swft_res_if;
	import swft_pkg::*;
	logic             valid;
	logic             ready;
	logic [EST_W-1:0] exported_estimate;
	logic [TOT_W-1:0] received_total;

	modport source (output valid, output exported_estimate, output received_total, input ready);
	modport sink (input valid, input exported_estimate, input received_total, output ready);
endinterface

// ===== design/swft_front.sv =====
module swft_front (
	input  logic          clk,
	input  logic          arst_n,
	swft_pkt_if.sink      pkt,
	output swft_pkg::cmd_t q_head,
	output logic          q_valid,
	input  logic          q_pop
);
	import swft_pkg::*;

	// Two-entry queue: full rate with a push and a pop in the same cycle.
	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	cmd_t       cmd;

	assign pkt.ready = (count_q != 2'd2);
	assign push      = pkt.valid && pkt.ready;
	assign pop       = q_pop && q_valid;
	assign q_valid   = (count_q != 2'd0);
	assign q_head    = mem_q[rd_ptr_q];

	always_comb begin
		cmd.clear = (pkt.mode == MODE_CLEAR);
		cmd.seq   = pkt.seq_no;
		cmd.cnt   = pkt.record_count;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/swft_back.sv =====
module swft_back (
	input  logic            clk,
	input  logic            arst_n,
	input  swft_pkg::cfg_wr_t cfg,
	input  swft_pkg::cmd_t  q_head,
	input  logic            q_valid,
	output logic            q_pop,
	swft_res_if.source      res
);
	import swft_pkg::*;

	logic [SEQ_W-1:0] wrap_top_q;
	logic [SEQ_W-1:0] wrap_bottom_q;
	logic [SEQ_W-1:0] seq_max_q;

	logic             awaiting_q;
	logic [SEQ_W-1:0] first_q;
	logic [SEQ_W-1:0] last_q;
	logic [TOT_W-1:0] total_q;

	logic             valid_s1;
	logic [SEQ_W-1:0] first_s1;
	logic [SEQ_W-1:0] last_s1;
	logic [TOT_W-1:0] total_s1;
	logic [CNT_W-1:0] batch_s1;

	logic             out_valid_q;
	logic [EST_W-1:0] est_q;
	logic [TOT_W-1:0] out_total_q;

	logic             adv_s1;
	logic [SEQ_W-1:0] nxt_first;
	logic [SEQ_W-1:0] nxt_last;
	logic [SEQ_W-1:0] wnd_last;
	logic [TOT_W:0]   sum;
	logic [TOT_W-1:0] nxt_total;
	logic [SEQ_W-1:0] span;
	logic [EST_W-1:0] est;

	assign adv_s1 = !out_valid_q || res.ready;
	assign q_pop  = q_valid && (!valid_s1 || adv_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_top_q    <= WRAP_TOP_RESET;
			wrap_bottom_q <= WRAP_BOTTOM_RESET;
			seq_max_q     <= SEQ_MAX_RESET;
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_WRAP_TOP:    wrap_top_q    <= cfg.data;
				REG_WRAP_BOTTOM: wrap_bottom_q <= cfg.data;
				REG_SEQ_MAX:     seq_max_q     <= cfg.data;
				default:         ;
			endcase
		end
	end

	// Window update: the wrap case may move the last mark before the
	// ordinary upward check, which then sees the moved value.
	always_comb begin
		nxt_first = first_q;
		wnd_last  = last_q;
		if (awaiting_q) begin
			nxt_first = q_head.seq;
			wnd_last  = q_head.seq;
		end else if (q_head.seq < first_q) begin
			if (first_q > wrap_top_q && q_head.seq < wrap_bottom_q) begin
				if (last_q >= wrap_bottom_q || last_q < q_head.seq) begin
					wnd_last = q_head.seq;
				end
			end
			nxt_first = q_head.seq;
		end
		nxt_last = wnd_last;
		if (!awaiting_q && q_head.seq > wnd_last &&
		    !(wnd_last < wrap_bottom_q && q_head.seq > wrap_top_q)) begin
			nxt_last = q_head.seq;
		end
		sum       = {1'b0, total_q} + {{(TOT_W+1-CNT_W){1'b0}}, q_head.cnt};
		nxt_total = sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			first_q    <= '0;
			last_q     <= '0;
			total_q    <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_head.clear) begin
					awaiting_q <= 1'b1;
					first_q    <= '0;
					last_q     <= '0;
					total_q    <= '0;
				end else begin
					awaiting_q <= 1'b0;
					first_q    <= nxt_first;
					last_q     <= nxt_last;
					total_q    <= nxt_total;
				end
			end
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (q_head.clear) begin
				first_s1 <= '0;
				last_s1  <= '0;
				total_s1 <= '0;
				batch_s1 <= '0;
			end else begin
				first_s1 <= nxt_first;
				last_s1  <= nxt_last;
				total_s1 <= nxt_total;
				batch_s1 <= q_head.cnt;
			end
		end
	end

	// Span is taken modulo 2^32 in both branches.
	always_comb begin
		if (last_s1 < first_s1) begin
			span = seq_max_q - first_s1 + last_s1;
		end else begin
			span = last_s1 - first_s1;
		end
		est = {1'b0, span} + {{(EST_W-CNT_W){1'b0}}, batch_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			est_q       <= est;
			out_total_q <= total_s1;
		end
	end

	assign res.valid             = out_valid_q;
	assign res.exported_estimate = est_q;
	assign res.received_total    = out_total_q;

endmodule

// ===== design/sequence_window_flow_tracker.sv =====
// Sequence window tracker for a flow-record export stream. Each word on pkt is
// either a clear (mode 1) or a packet header carrying an export sequence number
// and a record count; every word gives exactly one word on res with the
// exported-record estimate (modular window span plus the last record count)
// and the saturating total of records received since the last clear. The block
// takes one word per clock cycle while res is not stalled; each result passes
// the queue, window stage and output register. That rate is set by the window
// and total update in the back end, a loop through its own state registers. A
// two-word queue sits between front end and back end, and an output register
// holds the result, so a stall on res backs up through the pipeline without
// dropping words. The three limit registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while the block is idle
// (not enforced by the block). Writes to an index beyond the list are ignored.
module sequence_window_flow_tracker (
	input  logic                            clk,
	input  logic                            arst_n,
	swft_pkt_if.sink                        pkt,
	swft_res_if.source                      res,
	input  logic                            cfg_we,
	input  logic [swft_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swft_pkg::CFG_W-1:0]      cfg_data
);
	import swft_pkg::*;

	// Head of the queue as seen by the back end.
	cmd_t    q_head;
	logic    q_valid;
	logic    q_pop;
	cfg_wr_t cfg;

	// The configuration write is bundled so the back end sees one group.
	always_comb begin
		cfg.we    = cfg_we;
		cfg.index = cfg_index;
		cfg.data  = cfg_data;
	end

	// The front end decodes the mode and queues each accepted word.
	swft_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (pkt),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	// The back end owns the tracking state and the limit registers, updates
	// the window once per word and computes the estimate in its output stage.
	swft_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_head  (q_head),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule
